FILE: src/sfc_pkg.sv
package sfc_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 16;
  localparam int unsigned HDR_LEN = 6;
  localparam logic [15:0] START_WORD = 16'hA3A4;
  localparam logic [7:0] SEED_OFFSET = 8'h32;
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_CRC          = 3'd2,
    ST_START_WORD   = 3'd3,
    ST_LEN_BIG      = 3'd4,
    ST_KEY          = 3'd5,
    ST_LEN_MISMATCH = 3'd6
  } frame_status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } ctrl_state_e;

  typedef struct packed {
    frame_status_e status;
    logic [7:0]    key;
    logic [7:0]    cmd;
    logic [7:0]    seed;
    logic [7:0]    len;
  } verdict_t;

  function automatic logic [7:0] crc8_maxim_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/sfc_in_if.sv
interface sfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

FILE: src/sfc_out_if.sv
interface sfc_out_if import sfc_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          is_payload;
  logic [7:0]    value;
  frame_status_e frame_status;
  logic [7:0]    frame_key;
  logic [4:0]    payload_len;
  logic          last;

  modport source (output valid, output is_payload, output value, output frame_status,
                  output frame_key, output payload_len, output last, input ready);
  modport sink (input valid, input is_payload, input value, input frame_status,
                input frame_key, input payload_len, input last, output ready);
endinterface

FILE: src/sfc_pld_cell.sv
module sfc_pld_cell (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic [7:0] load_data_i,
  input  logic       shift_i,
  input  logic [7:0] shift_data_i,
  output logic [7:0] data_o
);

  logic [7:0] data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= shift_data_i;
    end
  end

  assign data_o = data_q;

endmodule

FILE: src/sfc_frame_check.sv
module sfc_frame_check import sfc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  localparam int unsigned MAX_FRAME = 7 + MAX_PAYLOAD,
  localparam int unsigned POS_W = $clog2(MAX_FRAME + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             frame_end_i,
  input  logic [7:0]       session_key_i,
  output logic [POS_W-1:0] pos_o,
  output verdict_t         verdict_o
);

  localparam int unsigned LW = ((POS_W > 8) ? POS_W : 8) + 1;

  logic [POS_W-1:0] pos_q;
  logic [7:0]       crc_q;
  logic             ovr_q;
  logic [7:0]       hdr_q [HDR_LEN];

  logic             at_max;
  logic             ovr_now;
  logic [LW-1:0]    flen;
  logic [LW-1:0]    flen_exp;
  logic [7:0]       seed;
  logic [7:0]       key;

  assign at_max = (pos_q >= POS_W'(MAX_FRAME));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '0;
      ovr_q <= 1'b0;
    end else if (accept_i) begin
      if (frame_end_i) begin
        pos_q <= '0;
        crc_q <= '0;
        ovr_q <= 1'b0;
      end else begin
        crc_q <= crc8_maxim_byte(crc_q, rx_byte_i);
        if (at_max) begin
          ovr_q <= 1'b1;
        end else begin
          pos_q <= pos_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && (pos_q < POS_W'(HDR_LEN))) begin
      hdr_q[pos_q[2:0]] <= rx_byte_i;
    end
  end

  assign ovr_now  = ovr_q || at_max;
  assign flen     = LW'(pos_q) + LW'(1);
  assign flen_exp = LW'(hdr_q[2]) + LW'(7);
  assign seed     = hdr_q[3] - SEED_OFFSET;
  assign key      = hdr_q[4] ^ seed;

  always_comb begin
    verdict_o.seed = seed;
    verdict_o.cmd  = hdr_q[5] ^ seed;
    verdict_o.len  = hdr_q[2];
    verdict_o.key  = key;
    if (!ovr_now && (pos_q <= POS_W'(6))) begin
      verdict_o.status = ST_SHORT;
      verdict_o.key    = '0;
    end else if (rx_byte_i != crc_q) begin
      verdict_o.status = ST_CRC;
    end else if ({hdr_q[0], hdr_q[1]} != START_WORD) begin
      verdict_o.status = ST_START_WORD;
    end else if (hdr_q[2] > 8'(MAX_PAYLOAD)) begin
      verdict_o.status = ST_LEN_BIG;
    end else if (ovr_now || (flen != flen_exp)) begin
      verdict_o.status = ST_LEN_MISMATCH;
    end else if ((session_key_i != '0) && (key != session_key_i)) begin
      verdict_o.status = ST_KEY;
    end else begin
      verdict_o.status = ST_OK;
    end
  end

  assign pos_o = pos_q;

endmodule

FILE: src/scrambled_frame_checker_crc8_top.sv
// channel   dir  handshake     payload
// rx_ch     in   valid/ready   rx_byte, frame_end
// res_ch    out  valid/ready   is_payload, value, frame_status, frame_key, payload_len, last
// cfg       in   cfg_we_i      cfg_wdata_i (session key)
//
// one byte is taken per cycle when idle and not stalled; a non-final byte gives no item
// the final byte gives a status item and, on a good frame, one item per payload
// byte, one per cycle while the output is not stalled, shifted out of the payload
// cell chain; input waits until the chain has drained into the output register;
// reset clears position, crc, overrun flag and output valid, no clearing pass;
// a stalled output register holds all input off
module scrambled_frame_checker_crc8_top import sfc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  sfc_in_if.sink     rx_ch,
  sfc_out_if.source  res_ch
);

  localparam int unsigned MAX_FRAME = 7 + MAX_PAYLOAD;
  localparam int unsigned POS_W = $clog2(MAX_FRAME + 1);
  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);

  ctrl_state_e      state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             out_isp_q;
  logic [7:0]       out_val_q;
  frame_status_e    out_st_q;
  logic [7:0]       out_key_q;
  logic [4:0]       out_len_q;
  logic             out_last_q;
  logic [7:0]       seed_q;
  logic [7:0]       key_q;
  logic [4:0]       len_q;
  logic [7:0]       session_key_q;

  logic             rx_fire;
  logic             res_fire;
  logic             out_free;
  logic             end_fire;
  logic             drain;
  logic             frame_ok;
  logic [POS_W-1:0] pos;
  verdict_t         verdict;
  logic [7:0]       cell_data [MAX_PAYLOAD];

  assign out_free = !out_valid_q || res_ch.ready;
  assign rx_ch.ready = (state_q == S_IDLE) && out_free;
  assign rx_fire  = rx_ch.valid && rx_ch.ready;
  assign res_fire = out_valid_q && res_ch.ready;
  assign end_fire = rx_fire && rx_ch.frame_end;
  assign drain    = (state_q == S_EMIT) && out_free;
  assign frame_ok = (verdict.status == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_key_q <= '0;
    end else if (cfg_we_i) begin
      session_key_q <= cfg_wdata_i;
    end
  end

  sfc_frame_check #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (rx_fire),
    .rx_byte_i     (rx_ch.rx_byte),
    .frame_end_i   (rx_ch.frame_end),
    .session_key_i (session_key_q),
    .pos_o         (pos),
    .verdict_o     (verdict)
  );

  for (genvar k = 0; k < MAX_PAYLOAD; k++) begin : g_cell
    logic [7:0] next_data;
    if (k == MAX_PAYLOAD - 1) begin : g_tail
      assign next_data = cell_data[k];
    end else begin : g_mid
      assign next_data = cell_data[k+1];
    end
    sfc_pld_cell u_cell (
      .clk_i        (clk_i),
      .load_i       (rx_fire && (pos == POS_W'(HDR_LEN + k))),
      .load_data_i  (rx_ch.rx_byte),
      .shift_i      (drain),
      .shift_data_i (next_data),
      .data_o       (cell_data[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (end_fire) begin
            out_valid_q <= 1'b1;
            if (frame_ok && (verdict.len != '0)) begin
              state_q <= S_EMIT;
              cnt_q   <= verdict.len[CNT_W-1:0];
            end
          end else if (res_fire) begin
            out_valid_q <= 1'b0;
          end
        end
        S_EMIT: begin
          if (drain) begin
            out_valid_q <= 1'b1;
            cnt_q       <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_fire) begin
      out_isp_q <= 1'b0;
      out_st_q  <= verdict.status;
      out_key_q <= verdict.key;
      seed_q    <= verdict.seed;
      key_q     <= verdict.key;
      len_q     <= verdict.len[4:0];
      if (frame_ok) begin
        out_val_q  <= verdict.cmd;
        out_len_q  <= verdict.len[4:0];
        out_last_q <= (verdict.len == '0);
      end else begin
        out_val_q  <= '0;
        out_len_q  <= '0;
        out_last_q <= 1'b1;
      end
    end else if (drain) begin
      out_isp_q  <= 1'b1;
      out_val_q  <= cell_data[0] ^ seed_q;
      out_st_q   <= ST_OK;
      out_key_q  <= key_q;
      out_len_q  <= len_q;
      out_last_q <= (cnt_q == CNT_W'(1));
    end
  end

  assign res_ch.valid        = out_valid_q;
  assign res_ch.is_payload   = out_isp_q;
  assign res_ch.value        = out_val_q;
  assign res_ch.frame_status = out_st_q;
  assign res_ch.frame_key    = out_key_q;
  assign res_ch.payload_len  = out_len_q;
  assign res_ch.last         = out_last_q;

  a_emit_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> out_valid_q)
    else $error("payload drain without an item in the output register");

  a_cnt_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) == (cnt_q != '0))
    else $error("payload count out of step with control state");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_st_q != ST_OK)) |-> (out_last_q && !out_isp_q))
    else $error("error status item not marked last");

  a_no_input_while_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |=> !$past(rx_fire))
    else $error("byte taken while payload drains");

endmodule
